// File: design/srfr_pkg.sv
// ---------------------------------------------------------------------------
// srfr_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// sync / length / crc16 frame receiver.
// ---------------------------------------------------------------------------
package srfr_pkg;

    localparam logic [7:0]  SYNC_FIRST        = 8'hAB;
    localparam logic [7:0]  SYNC_SECOND       = 8'hBA;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd48;

    // result kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // frame end status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_BAD = 2'd1;
    localparam logic [1:0] ST_LEN_BAD = 2'd2;

    // parser phases, one-hot
    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_SYNC2  = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CRC_HI = 6'b010000,
        PH_CRC_LO = 6'b100000
    } t_phase;

    // one result word
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic [1:0] frame_status;
    } t_result;

    // crc-16/ccitt-false update by one byte, poly 0x1021, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [15:0] r;
        t = crc[15:8] ^ b;
        t = t ^ {4'd0, t[7:4]};
        r = {crc[7:0], 8'd0};
        r = r ^ {t[3:0], 12'd0};
        r = r ^ {3'd0, t, 5'd0};
        r = r ^ {8'd0, t};
        return r;
    endfunction

endpackage

// File: design/srfr_parser.sv
// ---------------------------------------------------------------------------
// srfr_parser
// Frame parse state and running crc. Gives the result for the word
// presented on i_byte and advances its state when i_step is high.
// ---------------------------------------------------------------------------
module srfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_max_payload,
    output logic                o_res_valid,
    output srfr_pkg::t_result   o_res
);

    srfr_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_seen, n_seen;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [7:0]       seen_inc;
    logic [15:0]      crc_upd;
    logic [15:0]      crc_restart;

    assign seen_inc    = r_seen + 8'd1;
    assign crc_upd     = srfr_pkg::crc_byte(r_crc, i_byte);
    assign crc_restart = srfr_pkg::crc_byte(srfr_pkg::CRC_INIT, i_byte);

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_len       = r_len;
        n_seen      = r_seen;
        n_crc_hi    = r_crc_hi;
        o_res_valid = 1'b0;
        o_res       = '{kind: srfr_pkg::KIND_DATA, out_byte: 8'd0,
                        byte_index: 8'd0, frame_status: srfr_pkg::ST_OK};
        case (r_phase)
            srfr_pkg::PH_SYNC2: begin
                if (i_byte == srfr_pkg::SYNC_SECOND) begin
                    n_crc   = crc_upd;
                    n_phase = srfr_pkg::PH_LEN;
                end else if (i_byte == srfr_pkg::SYNC_FIRST) begin
                    n_crc   = crc_restart;
                    n_phase = srfr_pkg::PH_SYNC2;
                end else begin
                    n_phase = srfr_pkg::PH_HUNT;
                end
            end
            srfr_pkg::PH_LEN: begin
                n_len  = i_byte;
                n_seen = 8'd0;
                if (i_byte > i_max_payload) begin
                    n_phase            = srfr_pkg::PH_HUNT;
                    o_res_valid        = 1'b1;
                    o_res.kind         = srfr_pkg::KIND_END;
                    o_res.byte_index   = i_byte;
                    o_res.frame_status = srfr_pkg::ST_LEN_BAD;
                end else begin
                    n_crc   = crc_upd;
                    n_phase = (i_byte == 8'd0) ? srfr_pkg::PH_CRC_HI : srfr_pkg::PH_DATA;
                end
            end
            srfr_pkg::PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.out_byte   = i_byte;
                o_res.byte_index = r_seen;
                n_crc            = crc_upd;
                n_seen           = seen_inc;
                if (seen_inc == r_len) begin
                    n_phase = srfr_pkg::PH_CRC_HI;
                end
            end
            srfr_pkg::PH_CRC_HI: begin
                n_crc_hi = i_byte;
                n_phase  = srfr_pkg::PH_CRC_LO;
            end
            srfr_pkg::PH_CRC_LO: begin
                n_phase            = srfr_pkg::PH_HUNT;
                o_res_valid        = 1'b1;
                o_res.kind         = srfr_pkg::KIND_END;
                o_res.byte_index   = r_len;
                o_res.frame_status = ({r_crc_hi, i_byte} == r_crc) ?
                                     srfr_pkg::ST_OK : srfr_pkg::ST_CRC_BAD;
            end
            default: begin
                // hunting for the first sync byte
                if (i_byte == srfr_pkg::SYNC_FIRST) begin
                    n_crc   = crc_restart;
                    n_phase = srfr_pkg::PH_SYNC2;
                end else begin
                    n_phase = srfr_pkg::PH_HUNT;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= srfr_pkg::PH_HUNT;
            r_crc    <= srfr_pkg::CRC_INIT;
            r_len    <= 8'd0;
            r_seen   <= 8'd0;
            r_crc_hi <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

// File: design/sync_length_crc16_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// sync_length_crc16_frame_receiver_unit
// Framed packet receiver: sync pair, length, payload, crc-16/ccitt-false.
// ---------------------------------------------------------------------------
// Bytes enter on s_axis one word at a time. The block hunts for 0xAB 0xBA,
// reads a length byte, passes each payload byte on with its index
// (tuser = 0) and checks the big-endian crc that follows, giving one frame
// end word (tuser = 1) with status ok, crc mismatch or length too large.
// An accepted byte is held in the input register and its result, if any,
// is then registered in the output register, where it waits while the output
// is held; one byte per cycle is sustained while m_axis_tready is high. The
// max_payload register (reset 48) is to be written through the cfg port only
// while the block is idle; the block itself does not enforce this.
module sync_length_crc16_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,      // max_payload
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] out_byte, [15:8] byte_index,
                                         // [17:16] frame_status, [23:18] zero
    output logic [0:0]  m_axis_tuser     // [0] out_kind
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    srfr_pkg::t_result r_out;
    logic [7:0]        r_max_payload;
    logic              step;
    logic              res_valid;
    srfr_pkg::t_result res;

    // input word leaves when the output register is free or being drained
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= srfr_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    srfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.frame_status, r_out.byte_index, r_out.out_byte};
    assign m_axis_tuser  = r_out.kind;

    // payload words carry ok status
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == srfr_pkg::KIND_DATA) |->
            r_out.frame_status == srfr_pkg::ST_OK)
        else $error("payload word with nonzero status");

    // frame end words carry a zero byte and a defined status
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == srfr_pkg::KIND_END) |->
            (r_out.out_byte == 8'd0 && r_out.frame_status != 2'd3))
        else $error("malformed frame end word");

    // input stalls only when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without cause");

    // a result never appears without a consumed input word
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step))
        else $error("result without input word");

endmodule
